>>> hdl/assert_macros.svh
// Assertion macros for the RTL of the floor lookup block, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, switched off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/asfl_pkg.sv
// Package of the floor lookup block: defaults, the magic word and the microcode.
`default_nettype none

package asfl_pkg;

  // Defaults of the top level parameters.
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int ADDR_WIDTH_DEF  = 32;

  // Fixed field widths of the interface.
  localparam int COUNT_WIDTH  = 9;
  localparam int SLOT_WIDTH   = 8;
  localparam int FIELD_WIDTH  = 32;
  localparam int INDEX_WIDTH  = 8;

  // Tag that every loaded entry must carry.
  localparam logic [FIELD_WIDTH-1:0] ENTRY_MAGIC = 32'h00E6_7126;

  // Sequencer steps. The step counter wraps from the last step to the first.
  typedef enum logic [1:0] {
    STEP_IDLE  = 2'd0,
    STEP_START = 2'd1,
    STEP_SCAN  = 2'd2,
    STEP_EMIT  = 2'd3
  } step_t;

  // Jump conditions of a control word.
  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_NO_QUERY = 2'd1,
    COND_MORE     = 2'd2,
    COND_OUT_BUSY = 2'd3
  } cond_t;

  // One control word: datapath enables, then the jump taken when cond holds.
  typedef struct packed {
    logic  accept;
    logic  rd_en;
    logic  compare;
    logic  emit;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  localparam int PROGRAM_LENGTH = 4;

  localparam ctrl_word_t MICROCODE [PROGRAM_LENGTH] = '{
    // Idle: take transactions, stay here until a query is taken.
    '{accept: 1'b1, rd_en: 1'b0, compare: 1'b0, emit: 1'b0,
      cond: COND_NO_QUERY, target: STEP_IDLE},
    // Start: read entry 0.
    '{accept: 1'b0, rd_en: 1'b1, compare: 1'b0, emit: 1'b0,
      cond: COND_ALWAYS, target: STEP_SCAN},
    // Scan: compare the entry just read while the next one is read.
    '{accept: 1'b0, rd_en: 1'b1, compare: 1'b1, emit: 1'b0,
      cond: COND_MORE, target: STEP_SCAN},
    // Emit: wait for the output register, then fall through to idle.
    '{accept: 1'b0, rd_en: 1'b0, compare: 1'b0, emit: 1'b1,
      cond: COND_OUT_BUSY, target: STEP_EMIT}
  };

endpackage

`default_nettype wire

>>> hdl/asfl_ram.sv
// Generic single write port RAM with a registered read port.
`default_nettype none

module asfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/address_to_symbol_floor_lookup.sv
// Top level of the floor lookup block: microcoded scan over a table of start addresses.
// Timing: a load transaction gives its result in the cycle after it is taken; a query runs the
//   start, scan and emit steps, the scan comparing the first n entries, n being entry_count
//   clamped to MAX_ENTRIES. Throughput: one load per cycle while idle and the output is free;
//   the scan holds the one RAM read port, so no transaction is taken until the query is emitted.
// Reset clears the bad tag flag, entry_count and the handshake state; the table itself is not
//   cleared, and no clearing pass runs, so transactions are taken from the first cycle.
`default_nettype none

module address_to_symbol_floor_lookup #(
  parameter int MAX_ENTRIES = asfl_pkg::MAX_ENTRIES_DEF,
  parameter int ADDR_WIDTH  = asfl_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration: entry_count.
  input  wire logic                                cfg_we,
  input  wire logic [asfl_pkg::COUNT_WIDTH-1:0]    cfg_data,
  // Input channel.
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                kind,
  input  wire logic [asfl_pkg::SLOT_WIDTH-1:0]     slot,
  input  wire logic [asfl_pkg::FIELD_WIDTH-1:0]    slot_address,
  input  wire logic [asfl_pkg::FIELD_WIDTH-1:0]    slot_tag,
  input  wire logic [asfl_pkg::FIELD_WIDTH-1:0]    probe_address,
  // Output channel.
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [asfl_pkg::INDEX_WIDTH-1:0]    match_index,
  output logic      [asfl_pkg::FIELD_WIDTH-1:0]    offset,
  output logic                                     below_all,
  output logic                                     table_valid
);

  `include "assert_macros.svh"

  // Index width of the table, and a counter width that can also hold MAX_ENTRIES itself.
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // ---------------------------------------------------------------------------------------
  // Sequencer. The current step selects one control word from the microcode table; the
  // word enables parts of the datapath and names a jump taken when its condition holds.
  // Otherwise the step counter simply advances, wrapping from the emit step back to idle.
  // ---------------------------------------------------------------------------------------
  asfl_pkg::step_t      step;
  asfl_pkg::step_t      step_next;
  asfl_pkg::ctrl_word_t cw;
  logic                 jump;

  // Datapath registers.
  logic [CNT_W-1:0]      cnt;         // index of the entry being read
  logic [CNT_W-1:0]      data_idx;    // index of the entry now on the RAM output
  logic [CNT_W-1:0]      limit;       // entry_count clamped to MAX_ENTRIES
  logic [CNT_W-1:0]      limit_next;
  logic [ADDR_WIDTH-1:0] probe;
  logic [ADDR_WIDTH-1:0] best_addr;
  logic [ADDR_WIDTH-1:0] addr0;       // entry 0, used when nothing qualifies
  logic [IDX_W-1:0]      best_idx;
  logic                  found;
  logic                  bad_tag_seen;

  // Handshake and datapath decode.
  logic                  out_free;
  logic                  accepted;
  logic                  load_acc;
  logic                  query_acc;
  logic                  tag_bad;
  logic                  slot_ok;
  logic                  emit_now;
  logic                  take;
  logic [ADDR_WIDTH-1:0] rd_data;
  logic [ADDR_WIDTH-1:0] sel_addr;

  assign cw = asfl_pkg::MICROCODE[step];

  // The output register frees up in the same cycle as its transaction is taken.
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = cw.accept && out_free;
  assign accepted  = in_valid && in_ready;
  assign load_acc  = accepted && !kind;
  assign query_acc = accepted && kind;
  assign emit_now  = cw.emit && out_free;

  assign tag_bad = (slot_tag != asfl_pkg::ENTRY_MAGIC);
  assign slot_ok = (32'(slot) < 32'(MAX_ENTRIES));

  // An entry wins when it lies at or below the probe and strictly above the best so far,
  // so among equal addresses the lowest index, seen first, is kept.
  assign take = cw.compare && (data_idx < limit) && (rd_data <= probe)
                && (!found || (best_addr < rd_data));

  assign sel_addr = found ? best_addr : addr0;

  always_comb begin
    unique case (cw.cond)
      asfl_pkg::COND_ALWAYS:   jump = 1'b1;
      asfl_pkg::COND_NO_QUERY: jump = !query_acc;
      asfl_pkg::COND_MORE:     jump = (cnt < limit);
      asfl_pkg::COND_OUT_BUSY: jump = !out_free;
      default:                 jump = 1'b1;
    endcase
    step_next = jump ? cw.target : asfl_pkg::step_t'(2'(step + 2'd1));
  end

  // An entry_count above the table depth searches the whole table.
  always_comb begin
    if (32'(cfg_data) > 32'(MAX_ENTRIES)) begin
      limit_next = CNT_W'(MAX_ENTRIES);
    end else begin
      limit_next = CNT_W'(cfg_data);
    end
  end

  // ---------------------------------------------------------------------------------------
  // Table memory. Loads write through the one write port; the scan reads through the read
  // port, one entry per cycle, with the data registered inside the RAM.
  // ---------------------------------------------------------------------------------------
  asfl_ram #(
    .WIDTH (ADDR_WIDTH),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (load_acc && slot_ok),
    .waddr (IDX_W'(slot)),
    .wdata (ADDR_WIDTH'(slot_address)),
    .re    (cw.rd_en),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= asfl_pkg::STEP_IDLE;
      limit        <= '0;
      bad_tag_seen <= 1'b0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      step <= step_next;
      if (cfg_we) begin
        limit <= limit_next;
      end
      // The bad tag flag is sticky until reset.
      if (load_acc && tag_bad) begin
        bad_tag_seen <= 1'b1;
      end
      if (query_acc) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
      if (load_acc || emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers; none of them needs a reset.
  always_ff @(posedge clk) begin
    if (query_acc) begin
      probe    <= ADDR_WIDTH'(probe_address);
      cnt      <= '0;
      best_idx <= '0;
    end else if (cw.rd_en) begin
      cnt      <= CNT_W'(cnt + 1'b1);
      data_idx <= cnt;
    end
    // Entry 0 is always read first, whatever the count, and kept for the empty case.
    if (cw.compare && (data_idx == '0)) begin
      addr0 <= rd_data;
    end
    if (take) begin
      best_addr <= rd_data;
      best_idx  <= IDX_W'(data_idx);
    end
  end

  // Result register: a load reports only the flag after its own tag check.
  always_ff @(posedge clk) begin
    if (load_acc) begin
      match_index <= '0;
      offset      <= '0;
      below_all   <= 1'b0;
      table_valid <= !(bad_tag_seen || tag_bad);
    end else if (emit_now) begin
      match_index <= asfl_pkg::INDEX_WIDTH'(best_idx);
      offset      <= asfl_pkg::FIELD_WIDTH'(ADDR_WIDTH'(probe - sel_addr));
      below_all   <= !found;
      table_valid <= !bad_tag_seen;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------
  `ASSERT_CLK(a_ready_only_idle, in_ready |-> (step == asfl_pkg::STEP_IDLE),
    "transaction offered while the sequencer is busy")
  `ASSERT_CLK(a_best_not_above, found |-> (best_addr <= probe),
    "chosen entry lies above the probe")
  `ASSERT_CLK(a_emit_gives_result, emit_now |=> out_valid,
    "query result was not presented")
  `ASSERT_CLK(a_flag_sticky, $past(bad_tag_seen && !rst) |-> bad_tag_seen,
    "bad tag flag cleared without reset")

endmodule

`default_nettype wire

>>> verif/floor_lookup_checker.sv
// Transaction codes for the testbench, and the checker that predicts and compares results.

package asfl_tb_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

endpackage

module floor_lookup_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [asfl_pkg::COUNT_WIDTH-1:0]     cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic                                 kind,
  input  logic [asfl_pkg::SLOT_WIDTH-1:0]      slot,
  input  logic [asfl_pkg::FIELD_WIDTH-1:0]     slot_address,
  input  logic [asfl_pkg::FIELD_WIDTH-1:0]     slot_tag,
  input  logic [asfl_pkg::FIELD_WIDTH-1:0]     probe_address,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic [asfl_pkg::INDEX_WIDTH-1:0]     match_index,
  input  logic [asfl_pkg::FIELD_WIDTH-1:0]     offset,
  input  logic                                 below_all,
  input  logic                                 table_valid,
  output int unsigned                          mismatch_count,
  output int unsigned                          results_awaited
);

  import asfl_pkg::*;
  import asfl_tb_pkg::*;

  localparam int NUM_ENTRIES  = MAX_ENTRIES_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] match_index;
    logic [FIELD_WIDTH-1:0] offset;
    logic                   below_all;
    logic                   table_valid;
  } lookup_result_t;

  logic [FIELD_WIDTH-1:0] start_table [NUM_ENTRIES];
  logic                   bad_tag_seen;
  logic [COUNT_WIDTH-1:0] searched_count;
  int unsigned            failures;
  lookup_result_t         expected_results [$];

  // Greatest start address not above the probe; the lowest index wins a tie.
  function automatic lookup_result_t floor_of_probe(input logic [FIELD_WIDTH-1:0] probe);
    lookup_result_t r;
    int             limit;
    int             best;
    int             i;
    logic           found;
    limit = (searched_count > NUM_ENTRIES) ? NUM_ENTRIES : int'(searched_count);
    best  = 0;
    found = 1'b0;
    for (i = 0; i < limit; i++) begin
      if (start_table[i] <= probe && (!found || start_table[best] < start_table[i])) begin
        best  = i;
        found = 1'b1;
      end
    end
    r.match_index = best[INDEX_WIDTH-1:0];
    r.offset      = probe - start_table[best];
    r.below_all   = !found;
    r.table_valid = !bad_tag_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst) begin
      bad_tag_seen   = 1'b0;
      searched_count = '0;
      failures       = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        searched_count = cfg_data;
      end

      // Results leave in a later cycle than their transaction, so compare before pushing.
      if (out_valid && out_ready) begin
        got = {match_index, offset, below_all, table_valid};
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT) begin
            $display("%0t: unexpected result: index %0d offset %h below_all %b table_valid %b",
                     $time, got.match_index, got.offset, got.below_all, got.table_valid);
          end
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("%0t: mismatch: expected index %0d offset %h below_all %b valid %b",
                       $time, want.match_index, want.offset, want.below_all, want.table_valid);
              $display("%0t:           got      index %0d offset %h below_all %b valid %b",
                       $time, got.match_index, got.offset, got.below_all, got.table_valid);
            end
          end
        end
      end

      if (in_valid && in_ready) begin
        if (kind == KIND_LOAD) begin
          if (slot_tag != ENTRY_MAGIC) begin
            bad_tag_seen = 1'b1;
          end
          start_table[slot] = slot_address;
          want             = '0;
          want.table_valid = !bad_tag_seen;
        end else begin
          want = floor_of_probe(probe_address);
        end
        expected_results.push_back(want);
      end
    end
    results_awaited <= expected_results.size();
    mismatch_count  <= failures;
  end

endmodule

>>> verif/address_to_symbol_floor_lookup_tb.sv
// Testbench top of the floor lookup block: stimulus, handshake idling and the verdict.

module address_to_symbol_floor_lookup_tb;

  import asfl_pkg::*;
  import asfl_tb_pkg::*;

  localparam int NUM_ENTRIES     = MAX_ENTRIES_DEF;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int POOL_SIZE       = 8;
  // The drain is long enough for one query over a full table.
  localparam int DRAIN_CYCLES    = 300;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   cfg_we        = 1'b0;
  logic [COUNT_WIDTH-1:0] cfg_data      = '0;
  logic                   in_valid      = 1'b0;
  logic                   in_ready;
  logic                   kind          = KIND_LOAD;
  logic [SLOT_WIDTH-1:0]  slot          = '0;
  logic [FIELD_WIDTH-1:0] slot_address  = '0;
  logic [FIELD_WIDTH-1:0] slot_tag      = '0;
  logic [FIELD_WIDTH-1:0] probe_address = '0;
  logic                   out_valid;
  logic                   out_ready     = 1'b0;
  logic [INDEX_WIDTH-1:0] match_index;
  logic [FIELD_WIDTH-1:0] offset;
  logic                   below_all;
  logic                   table_valid;

  int unsigned mismatch_count;
  int unsigned results_awaited;

  // The stimulus keeps its own note of which slots hold an address. A query may only search
  // slots that have been loaded, and probes are steered towards the addresses stored there.
  logic                   slot_loaded [NUM_ENTRIES] = '{default: 1'b0};
  logic [FIELD_WIDTH-1:0] slot_shadow [NUM_ENTRIES];
  logic [FIELD_WIDTH-1:0] address_pool [POOL_SIZE];
  int unsigned            active_count   = 0;
  bit                     sender_idles   = 1'b1;
  bit                     receiver_idles = 1'b1;
  bit                     tags_random    = 1'b0;

  address_to_symbol_floor_lookup i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .slot          (slot),
    .slot_address  (slot_address),
    .slot_tag      (slot_tag),
    .probe_address (probe_address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .match_index   (match_index),
    .offset        (offset),
    .below_all     (below_all),
    .table_valid   (table_valid)
  );

  floor_lookup_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .slot            (slot),
    .slot_address    (slot_address),
    .slot_tag        (slot_tag),
    .probe_address   (probe_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .match_index     (match_index),
    .offset          (offset),
    .below_all       (below_all),
    .table_valid     (table_valid),
    .mismatch_count  (mismatch_count),
    .results_awaited (results_awaited)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit, far above the slowest legal run: every transaction a full-table query with the
  // longest sender gap and the longest receiver stall.
  initial begin
    #40_000_000;
    $display("address_to_symbol_floor_lookup_tb: done, errors");
    $finish;
  end

  // Receiver. For every result it draws a stall; ready is only lowered when the stall is not
  // zero, so with no stall it stays high across back-to-back transactions.
  initial begin
    int unsigned stall;
    forever begin
      stall = receiver_idles ? $urandom_range(0, 10) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Presents one transaction, after a random gap when the sender idles, and returns once taken.
  task automatic send_item(input logic k, input logic [SLOT_WIDTH-1:0] s,
                           input logic [FIELD_WIDTH-1:0] a, input logic [FIELD_WIDTH-1:0] t,
                           input logic [FIELD_WIDTH-1:0] p);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    kind          <= k;
    slot          <= s;
    slot_address  <= a;
    slot_tag      <= t;
    probe_address <= p;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (k == KIND_LOAD) begin
      slot_loaded[s] = 1'b1;
      slot_shadow[s] = a;
    end
  endtask

  // Holds the sender back until every expected result has been seen. The first edge lets the
  // checker's count take in the transaction accepted at the current edge.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The entry count is only changed while the block is idle.
  task automatic write_count(input int unsigned n);
    quiesce();
    cfg_we   <= 1'b1;
    cfg_data <= n[COUNT_WIDTH-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    active_count = n;
  endtask

  // Addresses cluster around the phase's pool so that equal and neighbouring addresses are
  // common, which is where ties and near misses happen.
  function automatic logic [FIELD_WIDTH-1:0] pick_address();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return address_pool[$urandom_range(0, POOL_SIZE - 1)];
      6:                return address_pool[$urandom_range(0, POOL_SIZE - 1)]
                               + $urandom_range(1, 3);
      7:                return address_pool[$urandom_range(0, POOL_SIZE - 1)]
                               - $urandom_range(1, 3);
      8:                return $urandom();
      default:          return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic random_item();
    logic [SLOT_WIDTH-1:0]  s;
    logic [FIELD_WIDTH-1:0] probe;
    logic [FIELD_WIDTH-1:0] near;
    int unsigned            searched;
    int unsigned            top_slot;
    int                     missing;
    int                     i;
    // Even an empty search reads entry 0 for the offset, so at least one entry must be loaded.
    searched = (active_count == 0) ? 1 : active_count;
    if ($urandom_range(0, 99) < 55) begin
      missing = -1;
      for (i = int'(searched) - 1; i >= 0; i--) begin
        if (!slot_loaded[i]) begin
          missing = i;
        end
      end
      if (missing < 0) begin
        near = slot_shadow[$urandom_range(0, searched - 1)];
        case ($urandom_range(0, 9))
          0, 1, 2: probe = near;
          3:       probe = near - 1;
          4:       probe = near + $urandom_range(1, 255);
          5, 6:    probe = pick_address();
          7:       probe = $urandom();
          8:       probe = '0;
          default: probe = '1;
        endcase
        send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), probe);
        return;
      end
      // A searched slot has never been loaded, so the query becomes a load of that slot.
      s = missing[SLOT_WIDTH-1:0];
    end else begin
      top_slot = (active_count + 3 > 255) ? 255 : active_count + 3;
      s = ($urandom_range(0, 9) < 7) ? SLOT_WIDTH'($urandom_range(0, top_slot))
                                     : SLOT_WIDTH'($urandom_range(0, 255));
    end
    send_item(KIND_LOAD, s, pick_address(),
              (tags_random && $urandom_range(0, 1)) ? $urandom() : ENTRY_MAGIC, $urandom());
  endtask

  initial begin
    int unsigned    ph;
    int unsigned    n;
    int unsigned    item;
    int unsigned    r;
    int unsigned    i;
    logic [FIELD_WIDTH-1:0] base;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Entry 0 is loaded first, since even an empty search reports its offset.
    send_item(KIND_LOAD, 8'd0, 32'h0000_1000, ENTRY_MAGIC, $urandom());
    // Empty table: the search covers nothing, so both probes come back below all entries.
    send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), 32'h0000_0000);
    send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), 32'hFFFF_FFFF);

    // Four entries, with entries 0 and 1 holding the same address so that the tie rule shows.
    write_count(4);
    send_item(KIND_LOAD, 8'd1, 32'h0000_1000, ENTRY_MAGIC, $urandom());
    send_item(KIND_LOAD, 8'd2, 32'hFFFF_FFFF, ENTRY_MAGIC, $urandom());
    send_item(KIND_LOAD, 8'd3, 32'h0000_0800, ENTRY_MAGIC, $urandom());
    // The top slot lies outside the search, so its zero address must not be chosen.
    send_item(KIND_LOAD, 8'd255, 32'h0000_0000, ENTRY_MAGIC, $urandom());
    send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), 32'h0000_07FF);
    send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), 32'h0000_0800);
    send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), 32'h0000_1000);
    send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), 32'hFFFF_FFFE);
    send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), 32'hFFFF_FFFF);
    send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), 32'h0000_0000);

    // A single searched entry: one probe below it and one above it.
    write_count(1);
    send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), 32'h0000_0FFF);
    send_item(KIND_QUERY, SLOT_WIDTH'($urandom()), $urandom(), $urandom(), 32'h0000_1234);

    // Random phases. Each one picks an entry count, a fresh address pool and an idling mode.
    // The early phases fix the extremes of the count; the last phase also sends bad tags,
    // because the invalid flag is sticky and only reset would clear it.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       n = 1;
        1:       n = 3;
        2:       n = 0;
        3:       n = NUM_ENTRIES;
        default: begin
          r = $urandom_range(0, 9);
          n = (r < 7) ? $urandom_range(1, 12) : (r < 9) ? $urandom_range(13, 64) : NUM_ENTRIES;
        end
      endcase

      base = $urandom();
      for (i = 0; i < POOL_SIZE; i++) begin
        address_pool[i] = (i < POOL_SIZE - 2) ? base + ($urandom_range(0, 4096) << 2)
                                              : $urandom();
      end

      sender_idles   = (ph % 4 == 0) || (ph % 4 == 1);
      receiver_idles = (ph % 4 == 0) || (ph % 4 == 2);
      tags_random    = (ph == RANDOM_PHASES - 1);

      // A full-table search needs every slot loaded, so the missing ones are filled first.
      if (n == NUM_ENTRIES) begin
        for (i = 0; i < NUM_ENTRIES; i++) begin
          if (!slot_loaded[i]) begin
            send_item(KIND_LOAD, i[SLOT_WIDTH-1:0], pick_address(), ENTRY_MAGIC, $urandom());
          end
        end
      end

      write_count(n);
      for (item = 0; item < ITEMS_PER_PHASE; item++) begin
        random_item();
      end
    end

    // Wait for the last results, then allow one full-table search for anything stray.
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_awaited == 0) begin
      $display("address_to_symbol_floor_lookup_tb: done, clean");
    end else begin
      $display("address_to_symbol_floor_lookup_tb: done, errors");
    end
    $finish;
  end

endmodule
